// File: design/dwsr_pkg.sv
package dwsr_pkg;

	// Fixed widths of the item fields and registers.
	localparam int PERIOD_W = 16;
	localparam int DUTY_W   = 14;
	localparam int SPEED_W  = 16;
	localparam int TARGET_W = 7;
	localparam int DBAND_W  = 8;
	localparam int STEP_W   = 10;
	localparam int NUMER_W  = 20;
	localparam int SUM_W    = 20;

	// Restoring divider, one per wheel lane: quotient width and step counter width.
	localparam int DIV_W = 20;
	localparam int CNT_W = $clog2(DIV_W);

	// Default for the averaging window length.
	localparam int WINDOW_LEN_DEF = 10;

	// Register file layout.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TARGET_LEFT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_RIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_STEP    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_CEILING = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_NUMER  = 3'd6;

	// Register reset values.
	localparam logic [TARGET_W-1:0] TARGET_RST  = 7'd50;
	localparam logic [DBAND_W-1:0]  DBAND_RST   = 8'd3;
	localparam logic [STEP_W-1:0]   STEP_RST    = 10'd20;
	localparam logic [DUTY_W-1:0]   FLOOR_RST   = 14'd100;
	localparam logic [DUTY_W-1:0]   CEILING_RST = 14'd10000;
	localparam logic [NUMER_W-1:0]  NUMER_RST   = 20'd250000;

	// Saturated speed.
	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

	typedef struct packed {
		logic [PERIOD_W-1:0] left_period;
		logic [PERIOD_W-1:0] right_period;
		logic                bump_hit;
		logic                start_request;
	} dwsr_in_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  left_duty;
		logic [DUTY_W-1:0]  right_duty;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		logic               still_running;
	} dwsr_out_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_left_rpm;
		logic [TARGET_W-1:0] target_right_rpm;
		logic [DBAND_W-1:0]  dead_band;
		logic [STEP_W-1:0]   duty_step;
		logic [DUTY_W-1:0]   duty_floor;
		logic [DUTY_W-1:0]   duty_ceiling;
		logic [NUMER_W-1:0]  speed_numerator;
	} dwsr_cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic win_upd;
		logic div_init;
		logic div_step;
		logic speed_upd;
		logic duty_upd;
		logic out_load;
	} dwsr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dwsr_stat_t;

endpackage

// File: design/dwsr_div.sv
module dwsr_div (
	input  logic                       clk,
	input  logic                       init,
	input  logic                       step,
	input  logic [dwsr_pkg::DIV_W-1:0] dividend,
	input  logic [dwsr_pkg::DIV_W-1:0] divisor,
	output logic [dwsr_pkg::DIV_W-1:0] quotient
);
	import dwsr_pkg::*;

	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// One quotient bit per step; a zero divisor yields an all-ones quotient.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (init) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

// File: design/dwsr_lane.sv
module dwsr_lane #(
	parameter int WINDOW_LEN = dwsr_pkg::WINDOW_LEN_DEF,
	parameter int SLOT_W     = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dwsr_pkg::dwsr_cmd_t           cmd,
	input  logic [SLOT_W-1:0]             slot,
	input  logic [dwsr_pkg::PERIOD_W-1:0] period,
	input  logic [dwsr_pkg::NUMER_W-1:0]  numerator,
	input  logic [dwsr_pkg::TARGET_W-1:0] target,
	input  logic [dwsr_pkg::DBAND_W-1:0]  dead_band,
	input  logic [dwsr_pkg::STEP_W-1:0]   duty_step,
	input  logic [dwsr_pkg::DUTY_W-1:0]   duty_floor,
	input  logic [dwsr_pkg::DUTY_W-1:0]   duty_ceiling,
	output logic [dwsr_pkg::DUTY_W-1:0]   duty,
	output logic [dwsr_pkg::SPEED_W-1:0]  speed
);
	import dwsr_pkg::*;

	localparam int CMP_W = SPEED_W + 2;
	localparam int ACC_W = DUTY_W + 1;

	// Reciprocal of the window length, exact for every window sum.
	localparam int     RCP_SH  = SUM_W + $clog2(WINDOW_LEN);
	localparam int     RCP_W   = SUM_W + 1;
	localparam int     PROD_W  = SUM_W + RCP_W;
	localparam longint RCP_ONE = longint'(1) << RCP_SH;
	localparam logic [RCP_W-1:0] RCP_M =
		RCP_W'((RCP_ONE + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN));

	logic [PERIOD_W-1:0] win_q [WINDOW_LEN];
	logic [SUM_W-1:0]    sum_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [DUTY_W-1:0]   duty_q;

	logic [PROD_W-1:0]   avg_prod;
	logic [DIV_W-1:0]    avg;
	logic [DIV_W-1:0]    div_dividend;
	logic [DIV_W-1:0]    div_divisor;
	logic [DIV_W-1:0]    quot;

	logic signed [CMP_W-1:0] spd_s;
	logic signed [CMP_W-1:0] band_hi;
	logic signed [CMP_W-1:0] band_lo;
	logic [ACC_W-1:0]        dec_thr;
	logic [ACC_W-1:0]        duty_mid;
	logic [DUTY_W-1:0]       duty_new;

	// Sample window and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (cmd.win_upd) begin
			win_q[slot] <= period;
			sum_q <= sum_q - SUM_W'(win_q[slot]) + SUM_W'(period);
		end
	end

	// The mean period comes from a reciprocal multiply of the window sum.
	assign avg_prod = PROD_W'(sum_q) * PROD_W'(RCP_M);
	assign avg      = DIV_W'(avg_prod >> RCP_SH);

	// The divider takes the numerator by the mean period.
	assign div_dividend = DIV_W'(numerator);
	assign div_divisor  = avg;

	dwsr_div u_div (
		.clk      (clk),
		.init     (cmd.div_init),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quot)
	);

	// Saturate the quotient; a zero average already gives an all-ones quotient.
	always_ff @(posedge clk) begin
		if (cmd.speed_upd) begin
			speed_q <= (quot[DIV_W-1:SPEED_W] != '0) ? SPEED_MAX : quot[SPEED_W-1:0];
		end
	end

	// Dead-band decision and duty step, then clamp to the limits.
	always_comb begin
		spd_s    = signed'(CMP_W'(speed_q));
		band_hi  = signed'(CMP_W'(target)) + signed'(CMP_W'(dead_band));
		band_lo  = signed'(CMP_W'(target)) - signed'(CMP_W'(dead_band));
		dec_thr  = ACC_W'(duty_step) + ACC_W'(duty_floor);
		duty_mid = ACC_W'(duty_q);
		if (spd_s > band_hi) begin
			if (ACC_W'(duty_q) >= dec_thr) begin
				duty_mid = ACC_W'(duty_q) - ACC_W'(duty_step);
			end else begin
				duty_mid = ACC_W'(duty_floor);
			end
		end else if (spd_s < band_lo) begin
			duty_mid = ACC_W'(duty_q) + ACC_W'(duty_step);
		end
		if (duty_mid < ACC_W'(duty_floor)) begin
			duty_new = duty_floor;
		end else if (duty_mid > ACC_W'(duty_ceiling)) begin
			duty_new = duty_ceiling;
		end else begin
			duty_new = duty_mid[DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
		end else if (cmd.duty_upd) begin
			duty_q <= duty_new;
		end
	end

	assign duty  = duty_q;
	assign speed = speed_q;

endmodule

// File: design/dwsr_datapath.sv
module dwsr_datapath #(
	parameter int WINDOW_LEN = dwsr_pkg::WINDOW_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dwsr_pkg::dwsr_cmd_t  cmd,
	output dwsr_pkg::dwsr_stat_t stat,
	input  dwsr_pkg::dwsr_in_t   in_data,
	input  dwsr_pkg::dwsr_cfg_t  cfg,
	input  logic                 out_ready,
	output logic                 out_valid,
	output dwsr_pkg::dwsr_out_t  out_data
);
	import dwsr_pkg::*;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [SLOT_W-1:0]  slot_q;
	logic               bump_q;
	logic [DUTY_W-1:0]  left_duty;
	logic [DUTY_W-1:0]  right_duty;
	logic [SPEED_W-1:0] left_speed;
	logic [SPEED_W-1:0] right_speed;
	logic               out_valid_q;
	dwsr_out_t          out_q;

	// Window slot advances once per evaluated tick; the bump flag is kept for the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.win_upd) begin
			if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_upd) begin
			bump_q <= in_data.bump_hit;
		end
	end

	dwsr_lane #(
		.WINDOW_LEN (WINDOW_LEN),
		.SLOT_W     (SLOT_W)
	) u_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.slot         (slot_q),
		.period       (in_data.left_period),
		.numerator    (cfg.speed_numerator),
		.target       (cfg.target_left_rpm),
		.dead_band    (cfg.dead_band),
		.duty_step    (cfg.duty_step),
		.duty_floor   (cfg.duty_floor),
		.duty_ceiling (cfg.duty_ceiling),
		.duty         (left_duty),
		.speed        (left_speed)
	);

	dwsr_lane #(
		.WINDOW_LEN (WINDOW_LEN),
		.SLOT_W     (SLOT_W)
	) u_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.slot         (slot_q),
		.period       (in_data.right_period),
		.numerator    (cfg.speed_numerator),
		.target       (cfg.target_right_rpm),
		.dead_band    (cfg.dead_band),
		.duty_step    (cfg.duty_step),
		.duty_floor   (cfg.duty_floor),
		.duty_ceiling (cfg.duty_ceiling),
		.duty         (right_duty),
		.speed        (right_speed)
	);

	// Output register: holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.left_duty     <= left_duty;
			out_q.right_duty    <= right_duty;
			out_q.left_speed    <= left_speed;
			out_q.right_speed   <= right_speed;
			out_q.still_running <= ~bump_q;
		end
	end

	assign stat.out_busy = out_valid_q & ~out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

// File: design/dwsr_ctrl.sv
module dwsr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 start_request,
	input  logic                 bump_hit,
	output logic                 in_ready,
	input  dwsr_pkg::dwsr_stat_t stat,
	output dwsr_pkg::dwsr_cmd_t  cmd
);
	import dwsr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b00_0001,
		ST_SPD_INIT = 6'b00_0010,
		ST_SPD_RUN  = 6'b00_0100,
		ST_SPEED    = 6'b00_1000,
		ST_DUTY     = 6'b01_0000,
		ST_DONE     = 6'b10_0000
	} dwsr_state_t;

	dwsr_state_t      state_q;
	dwsr_state_t      state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             enabled_q;
	logic             accept;
	logic             en_now;
	logic             div_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign en_now   = enabled_q | start_request;
	assign div_last = (cnt_q == CNT_W'(DIV_W - 1));

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && en_now) begin
					cmd.win_upd = 1'b1;
					state_nxt   = ST_SPD_INIT;
				end
			end
			ST_SPD_INIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_SPD_RUN;
			end
			ST_SPD_RUN: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_nxt = ST_SPEED;
				end
			end
			ST_SPEED: begin
				cmd.speed_upd = 1'b1;
				state_nxt     = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.duty_upd = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State, divider step count and the enable flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			enabled_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				enabled_q <= en_now & ~bump_hit;
			end
		end
	end

endmodule

// File: design/dual_wheel_deadband_speed_regulator.sv
// Dual-wheel dead-band speed regulator.
// Input channel (in_valid/in_ready/in_data): one control tick carrying the left and
// right tachometer periods, a bump flag and a start request. Output channel
// (out_valid/out_ready/out_data): new duties, measured speeds and a running flag.
// A start request enables the controller; a tick taken while disabled gives no
// result. A bump disables the controller after that tick's result.
// An evaluated tick runs through the divider load, one 20-step pass of the restoring
// divider in each wheel lane (numerator by the mean period, which a reciprocal
// multiply gives), the speed and duty updates and the output register load.
// A tick that is not evaluated leaves the controller idle. in_ready is high only
// while no tick is in work. The result sits in an output register, so the next
// tick can be taken while it waits; if the receiver stalls, a finished tick waits
// for that register to free. Reset clears the windows, sums, duties and the enable
// flag and loads the register defaults. Configuration is to be written over the APB
// port by the user only while idle; the block itself does not enforce this.
module dual_wheel_deadband_speed_regulator #(
	parameter int WINDOW_LEN = dwsr_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  dwsr_pkg::dwsr_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dwsr_pkg::dwsr_out_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dwsr_pkg::PADDR_W-1:0]  paddr,
	input  logic [dwsr_pkg::PDATA_W-1:0]  pwdata,
	output logic [dwsr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import dwsr_pkg::*;

	dwsr_cfg_t            cfg_q;
	dwsr_cmd_t            cmd;
	dwsr_stat_t           stat;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_left_rpm  <= TARGET_RST;
			cfg_q.target_right_rpm <= TARGET_RST;
			cfg_q.dead_band        <= DBAND_RST;
			cfg_q.duty_step        <= STEP_RST;
			cfg_q.duty_floor       <= FLOOR_RST;
			cfg_q.duty_ceiling     <= CEILING_RST;
			cfg_q.speed_numerator  <= NUMER_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TARGET_LEFT:  cfg_q.target_left_rpm  <= pwdata[TARGET_W-1:0];
				REG_TARGET_RIGHT: cfg_q.target_right_rpm <= pwdata[TARGET_W-1:0];
				REG_DEAD_BAND:    cfg_q.dead_band        <= pwdata[DBAND_W-1:0];
				REG_DUTY_STEP:    cfg_q.duty_step        <= pwdata[STEP_W-1:0];
				REG_DUTY_FLOOR:   cfg_q.duty_floor       <= pwdata[DUTY_W-1:0];
				REG_DUTY_CEILING: cfg_q.duty_ceiling     <= pwdata[DUTY_W-1:0];
				REG_SPEED_NUMER:  cfg_q.speed_numerator  <= pwdata[NUMER_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_TARGET_LEFT:  prdata = PDATA_W'(cfg_q.target_left_rpm);
			REG_TARGET_RIGHT: prdata = PDATA_W'(cfg_q.target_right_rpm);
			REG_DEAD_BAND:    prdata = PDATA_W'(cfg_q.dead_band);
			REG_DUTY_STEP:    prdata = PDATA_W'(cfg_q.duty_step);
			REG_DUTY_FLOOR:   prdata = PDATA_W'(cfg_q.duty_floor);
			REG_DUTY_CEILING: prdata = PDATA_W'(cfg_q.duty_ceiling);
			REG_SPEED_NUMER:  prdata = PDATA_W'(cfg_q.speed_numerator);
			default:          prdata = '0;
		endcase
	end

	dwsr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.start_request (in_data.start_request),
		.bump_hit      (in_data.bump_hit),
		.in_ready      (in_ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	dwsr_datapath #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// A start request always leads to an evaluated tick.
	a_start_evaluates: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.start_request |=> !in_ready)
		else $error("start request did not begin an evaluation");

	// The window only moves on an accepted transaction.
	a_window_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_upd |-> in_valid && in_ready)
		else $error("window updated without an accepted transaction");

	// A new result never overwrites one the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || out_ready)
		else $error("result register overwritten while stalled");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dwsr_pkg::*;

	localparam int WINDOW = WINDOW_LEN_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;
	// Address slot past the last register; writes there must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		dwsr_in_t tick;
		bit       wait_drain;
	} tick_job_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	dwsr_in_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	dwsr_out_t           out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Ticks waiting to be driven and the reports the regulator owes us.
	tick_job_t           ticks_to_send[$];
	dwsr_out_t           reports_due[$];
	bit                  tick_taken = 1'b0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  fault_count = 0;
	int                  cycle_count = 0;
	bit                  gen_bumped = 1'b1;

	// Shadow of the regulator: registers, sample windows, sums, duties, enable.
	dwsr_cfg_t           regs;
	logic [15:0]         lwin[WINDOW];
	logic [15:0]         rwin[WINDOW];
	int                  wslot;
	logic [19:0]         lsum;
	logic [19:0]         rsum;
	logic [13:0]         lduty;
	logic [13:0]         rduty;
	bit                  ctl_on;

	dual_wheel_deadband_speed_regulator #(
		.WINDOW_LEN(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Speed from a window sum: mean period into the numerator, saturated.
	function automatic logic [15:0] wheel_speed(input logic [19:0] sum);
		int unsigned mean;
		int unsigned quo;
		mean = sum / WINDOW;
		if (mean == 0)
			return SPEED_MAX;
		quo = regs.speed_numerator / mean;
		return (quo > 65535) ? SPEED_MAX : quo[15:0];
	endfunction

	// One bang-bang step with dead band, then the clamp to floor and ceiling.
	function automatic logic [13:0] next_duty(input logic [13:0] duty,
			input logic [15:0] speed, input logic [6:0] target);
		int spd;
		int goal;
		int band;
		int x;
		int step;
		int lo_lim;
		int hi_lim;
		spd = speed;
		goal = target;
		band = regs.dead_band;
		x = duty;
		step = regs.duty_step;
		lo_lim = regs.duty_floor;
		hi_lim = regs.duty_ceiling;
		if (spd > goal + band) begin
			// Stepping down stops at the floor instead of wrapping.
			if (x >= step + lo_lim)
				x = x - step;
			else
				x = lo_lim;
		end else if (spd < goal - band) begin
			x = x + step;
		end
		if (x < lo_lim)
			x = lo_lim;
		else if (x > hi_lim)
			x = hi_lim;
		return x[13:0];
	endfunction

	// Advance the shadow by one tick; returns 1 when the tick yields a report.
	function automatic bit regulate_tick(input dwsr_in_t t, output dwsr_out_t r);
		logic [15:0] ls;
		logic [15:0] rs;
		r = '0;
		if (t.start_request)
			ctl_on = 1'b1;
		if (!ctl_on)
			return 1'b0;
		lsum = lsum - lwin[wslot] + t.left_period;
		rsum = rsum - rwin[wslot] + t.right_period;
		lwin[wslot] = t.left_period;
		rwin[wslot] = t.right_period;
		wslot = (wslot == WINDOW - 1) ? 0 : wslot + 1;
		ls = wheel_speed(lsum);
		rs = wheel_speed(rsum);
		lduty = next_duty(lduty, ls, regs.target_left_rpm);
		rduty = next_duty(rduty, rs, regs.target_right_rpm);
		if (t.bump_hit)
			ctl_on = 1'b0;
		r.left_duty = lduty;
		r.right_duty = rduty;
		r.left_speed = ls;
		r.right_speed = rs;
		r.still_running = !t.bump_hit;
		return 1'b1;
	endfunction

	// A period that puts the wheel near its target, give or take the dead band plus eight.
	function automatic logic [15:0] period_near(input int target);
		int band;
		int rpm;
		int per;
		int wiggle;
		band = regs.dead_band;
		rpm = target + int'($urandom_range(0, 2 * band + 16)) - (band + 8);
		if (rpm < 1)
			rpm = 1;
		per = int'(regs.speed_numerator) / rpm;
		wiggle = per / 16 + 2;
		per = per - int'($urandom_range(0, wiggle)) + int'($urandom_range(0, wiggle));
		if (per < 0)
			per = 0;
		if (per > 65535)
			per = 65535;
		return per[15:0];
	endfunction

	function automatic logic [15:0] noise_period();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly plausible tachometer readings; a fifth of the ticks are noise.
	function automatic tick_job_t random_tick();
		tick_job_t j;
		j.wait_drain = ($urandom_range(0, 199) == 0);
		if ($urandom_range(0, 99) < 80) begin
			j.tick.left_period = period_near(regs.target_left_rpm);
			j.tick.right_period = period_near(regs.target_right_rpm);
			j.tick.start_request = gen_bumped ? ($urandom_range(0, 3) != 0)
				: ($urandom_range(0, 9) == 0);
			j.tick.bump_hit = ($urandom_range(0, 39) == 0);
		end else begin
			j.tick.left_period = noise_period();
			j.tick.right_period = noise_period();
			j.tick.start_request = 1'($urandom_range(0, 1));
			j.tick.bump_hit = ($urandom_range(0, 4) == 0);
		end
		if (j.tick.bump_hit)
			gen_bumped = 1'b1;
		else if (j.tick.start_request)
			gen_bumped = 1'b0;
		return j;
	endfunction

	// Register values: a quarter of the draws land on an end of the range.
	function automatic int pick_setting(input int lo, input int hi);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? lo : hi;
		return $urandom_range(lo, hi);
	endfunction

	task automatic push_tick(input int lp, input int rp, input bit bump, input bit start,
			input bit drain);
		tick_job_t j;
		j.tick.left_period = lp[15:0];
		j.tick.right_period = rp[15:0];
		j.tick.bump_hit = bump;
		j.tick.start_request = start;
		j.wait_drain = drain;
		ticks_to_send.push_back(j);
	endtask

	task automatic queue_random(input int count);
		repeat (count)
			ticks_to_send.push_back(random_tick());
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_TARGET_LEFT:  regs.target_left_rpm = value[TARGET_W-1:0];
			REG_TARGET_RIGHT: regs.target_right_rpm = value[TARGET_W-1:0];
			REG_DEAD_BAND:    regs.dead_band = value[DBAND_W-1:0];
			REG_DUTY_STEP:    regs.duty_step = value[STEP_W-1:0];
			REG_DUTY_FLOOR:   regs.duty_floor = value[DUTY_W-1:0];
			REG_DUTY_CEILING: regs.duty_ceiling = value[DUTY_W-1:0];
			REG_SPEED_NUMER:  regs.speed_numerator = value[NUMER_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(input int tl, input int tr, input int band, input int step,
			input int lo_lim, input int hi_lim, input int numer);
		write_reg(REG_TARGET_LEFT, tl);
		write_reg(REG_TARGET_RIGHT, tr);
		write_reg(REG_DEAD_BAND, band);
		write_reg(REG_DUTY_STEP, step);
		write_reg(REG_DUTY_FLOOR, lo_lim);
		write_reg(REG_DUTY_CEILING, hi_lim);
		write_reg(REG_SPEED_NUMER, numer);
	endtask

	// Block until every tick is sent and every report is back, then let it settle.
	task automatic wait_quiet();
		while (ticks_to_send.size() != 0 || in_valid || reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Tick driver: a new transaction goes out only once the last one is taken.
	always @(negedge clk) begin : drive_ticks
		tick_job_t job;
		if (arst_n) begin
			if (!in_valid || tick_taken) begin
				if (ticks_to_send.size() != 0
						&& int'($urandom_range(0, 99)) >= send_idle_pct
						&& !(ticks_to_send[0].wait_drain && reports_due.size() != 0)) begin
					job = ticks_to_send.pop_front();
					in_data <= job.tick;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
		end
	end

	// Monitor: check each report against the oldest prediction, then predict.
	always @(posedge clk) begin : watch_ports
		dwsr_out_t want;
		if (arst_n) begin
			tick_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected report, expected none, got %h",
						$time, out_data);
				end else begin
					want = reports_due.pop_front();
					if (out_data.left_duty !== want.left_duty
							|| out_data.right_duty !== want.right_duty
							|| out_data.left_speed !== want.left_speed
							|| out_data.right_speed !== want.right_speed
							|| out_data.still_running !== want.still_running) begin
						fault_count++;
						$display("%0t: mismatch, expected %h, got %h",
							$time, want, out_data);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (regulate_tick(in_data, want))
					reports_due.push_back(want);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : run
		int i;
		regs.target_left_rpm = TARGET_RST;
		regs.target_right_rpm = TARGET_RST;
		regs.dead_band = DBAND_RST;
		regs.duty_step = STEP_RST;
		regs.duty_floor = FLOOR_RST;
		regs.duty_ceiling = CEILING_RST;
		regs.speed_numerator = NUMER_RST;
		for (i = 0; i < WINDOW; i++) begin
			lwin[i] = '0;
			rwin[i] = '0;
		end
		wslot = 0;
		lsum = '0;
		rsum = '0;
		lduty = '0;
		rduty = '0;
		ctl_on = 1'b0;

		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset settings.
		send_idle_pct = 25;
		recv_idle_pct = 60;
		// Disabled tick, then start on an all-zero window (zero mean period).
		push_tick(5000, 5000, 1'b0, 1'b0, 1'b0);
		push_tick(0, 0, 1'b0, 1'b1, 1'b0);
		push_tick(65535, 65535, 1'b0, 1'b0, 1'b0);
		// Bump together with start: evaluated, then disabled.
		push_tick(65535, 0, 1'b1, 1'b1, 1'b0);
		push_tick(1234, 1234, 1'b0, 1'b0, 1'b0);
		push_tick(16'hAAAA, 16'h5555, 1'b0, 1'b1, 1'b0);
		push_tick(16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0);
		// A full window of tiny periods saturates the left speed; slot wraps.
		repeat (WINDOW)
			push_tick(1, 20, 1'b0, 1'b0, 1'b0);
		// Sender holds off until all reports are in, then a run ending in a bump.
		push_tick(5000, 5300, 1'b0, 1'b0, 1'b1);
		repeat (5)
			push_tick(5000, 5300, 1'b0, 1'b0, 1'b0);
		push_tick(5000, 5300, 1'b1, 1'b0, 1'b0);
		wait_quiet();

		// Zero target with a wide band: the lower bound goes negative.
		set_regs(0, 120, 3, 1, 0, 10000, 250000);
		write_reg(REG_DEAD_BAND, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		queue_random(250);
		wait_quiet();

		send_idle_pct = 60;
		recv_idle_pct = 25;
		set_regs(120, 0, 0, 1000, 10000, 10000, 1048575);
		queue_random(250);
		wait_quiet();

		// Floor above ceiling.
		set_regs(60, 30, 5, 37, 9000, 2000, 200000);
		queue_random(150);
		wait_quiet();

		set_regs(7, 50, 0, 500, 0, 0, 1);
		queue_random(100);
		wait_quiet();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (4) begin
			set_regs(pick_setting(0, 120), pick_setting(0, 120), pick_setting(0, 255),
				pick_setting(1, 1000), pick_setting(0, 10000), pick_setting(0, 10000),
				pick_setting(1, 1048575));
			queue_random(200);
			wait_quiet();
		end

		if (fault_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
